[src/hsec_pkg.sv]
// Shared types, constants and bit-placement functions for the Hamming SEC codec.
`default_nettype none

package hsec_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_BITS       = 63;
  localparam int CHK_BITS      = 6;
  localparam int DB_W          = 6;

  typedef logic [CW_BITS-1:0]       cw_t;
  typedef logic [MAX_DATA_BITS-1:0] data_t;
  typedef logic [CHK_BITS-1:0]      chk_t;
  typedef logic [DB_W-1:0]          db_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DATA_BITS  = 1'b0,
    CFG_PARITY_ODD = 1'b1
  } cfg_idx_t;

  // Operation codes
  typedef enum logic [0:0] {
    FUNC_ENCODE  = 1'b0,
    FUNC_CORRECT = 1'b1
  } func_t;

  // Context carried down the pipeline with each word
  typedef struct packed {
    func_t        func;
    logic         odd;
    logic [2:0]   nchk;
    db_t          total;
  } ctx_t;

  function automatic logic is_pow2(input int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Data bit k goes to the k-th non-power-of-two position
  function automatic cw_t scatter(input data_t d);
    cw_t cw;
    int  k;
    cw = '0;
    k  = 0;
    for (int p = 1; p <= CW_BITS; p++) begin
      if (!is_pow2(p)) begin
        cw[p-1] = d[k];
        k++;
      end
    end
    return cw;
  endfunction

  function automatic data_t gather(input cw_t cw);
    data_t d;
    int    k;
    d = '0;
    k = 0;
    for (int p = 1; p <= CW_BITS; p++) begin
      if (!is_pow2(p)) begin
        d[k] = cw[p-1];
        k++;
      end
    end
    return d;
  endfunction

  // Positions covered by check bit i
  function automatic cw_t group_mask(input int i);
    cw_t m;
    for (int p = 1; p <= CW_BITS; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Mask of the low n bits, n up to 63
  function automatic cw_t low_mask(input db_t n);
    logic [63:0] m;
    m = ~(64'hFFFF_FFFF_FFFF_FFFF << n);
    return m[CW_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[src/hamming_sec_encode_correct_top.sv]
// Top level of the pipelined Hamming SEC encoder and corrector.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | start, busy               | func, word
//  result   | done (one-cycle strobe)   | codeword, data_out, syndrome, corrected,
//           |                           | bad_syndrome
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One word per cycle; each result is registered through the stages below.
// Stages: input masking and data placement, check-bit XOR trees, correction
// and data extraction into the output registers.
// busy stays low: the result side never stalls, so no stage ever holds.
// rst (synchronous) clears the stage valid bits and sets 11 data bits, even parity.
`default_nettype none

module hamming_sec_encode_correct_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   func,
  input  wire logic [62:0]            word,
  output logic                        done,
  output logic [62:0]                 codeword,
  output logic [56:0]                 data_out,
  output logic [5:0]                  syndrome,
  output logic                        corrected,
  output logic                        bad_syndrome,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [5:0]             cfg_data
);
  import hsec_pkg::*;

  // Configuration registers
  db_t  dlen;
  logic parity_odd;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dlen       <= db_t'(11);
      parity_odd <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DATA_BITS:  dlen       <= cfg_data;
        CFG_PARITY_ODD: parity_odd <= cfg_data[0];
      endcase
    end
  end

  // Effective length and check count
  db_t        d_eff;
  logic [2:0] nchk;
  db_t        total;

  always_comb begin
    if (dlen == '0) begin
      d_eff = db_t'(1);
    end else if (dlen > db_t'(MAX_DATA_BITS)) begin
      d_eff = db_t'(MAX_DATA_BITS);
    end else begin
      d_eff = dlen;
    end
    if (d_eff <= db_t'(1)) begin
      nchk = 3'd2;
    end else if (d_eff <= db_t'(4)) begin
      nchk = 3'd3;
    end else if (d_eff <= db_t'(11)) begin
      nchk = 3'd4;
    end else if (d_eff <= db_t'(26)) begin
      nchk = 3'd5;
    end else begin
      nchk = 3'd6;
    end
    total = d_eff + db_t'(nchk);
  end

  // Stage 1: mask the input and place data bits
  logic  s1_valid;
  cw_t   s1_cw;
  ctx_t  s1_ctx;
  cw_t   s1_cw_next;
  data_t enc_data;
  cw_t   len_mask;

  always_comb begin
    len_mask = low_mask(d_eff);
    enc_data = data_t'(word) & len_mask[MAX_DATA_BITS-1:0];
    if (func_t'(func) == FUNC_ENCODE) begin
      s1_cw_next = scatter(enc_data);
    end else begin
      s1_cw_next = word & low_mask(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_cw  <= s1_cw_next;
    s1_ctx <= '{func: func_t'(func), odd: parity_odd, nchk: nchk, total: total};
  end

  // Stage 2: group parities, giving check bits or syndrome
  logic s2_valid;
  cw_t  s2_cw;
  ctx_t s2_ctx;
  chk_t s2_chk;
  chk_t chk_next;

  always_comb begin
    for (int i = 0; i < CHK_BITS; i++) begin
      chk_next[i] = (^(s1_cw & group_mask(i)) ^ s1_ctx.odd) && (i < int'(s1_ctx.nchk));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_cw  <= s1_cw;
    s2_ctx <= s1_ctx;
    s2_chk <= chk_next;
  end

  // Stage 3: insert check bits or correct, then extract data
  cw_t  cw_fix;
  chk_t syn_next;
  logic bad_next;
  logic corr_next;

  always_comb begin
    cw_fix    = s2_cw;
    syn_next  = '0;
    bad_next  = 1'b0;
    corr_next = 1'b0;
    if (s2_ctx.func == FUNC_ENCODE) begin
      for (int i = 0; i < CHK_BITS; i++) begin
        cw_fix[(1 << i) - 1] = s2_chk[i];
      end
    end else begin
      syn_next = s2_chk;
      if (s2_chk > s2_ctx.total) begin
        bad_next = 1'b1;
      end else if (s2_chk != '0) begin
        corr_next = 1'b1;
        cw_fix    = s2_cw ^ (cw_t'(1) << (s2_chk - chk_t'(1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    codeword     <= cw_fix;
    data_out     <= gather(cw_fix);
    syndrome     <= syn_next;
    corrected    <= corr_next;
    bad_syndrome <= bad_next;
  end

endmodule

`default_nettype wire

[src/hsec_checker.sv]
// Port-level checker for the Hamming SEC codec, bound to the top level.
`default_nettype none

module hsec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [5:0]  syndrome,
  input wire logic        corrected,
  input wire logic        bad_syndrome
);

  // Every accepted transaction gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##2 done)
    else $error("accepted transaction gave no result");

  // No result without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a transaction");

  // A flip is never made on a bad syndrome
  a_corr_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(corrected && bad_syndrome))
    else $error("corrected and bad_syndrome together");

  // Corrected or bad implies a nonzero syndrome
  a_corr_syn: assert property (@(posedge clk) disable iff (rst)
    (done && (corrected || bad_syndrome)) |-> (syndrome != 6'd0))
    else $error("flag set with zero syndrome");

endmodule

bind hamming_sec_encode_correct_top hsec_checker u_hsec_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .syndrome(syndrome),
  .corrected(corrected),
  .bad_syndrome(bad_syndrome)
);

`default_nettype wire
